FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

    typedef logic [1:0]  op_t;
    typedef logic [3:0]  slot_t;
    typedef logic [7:0]  prio_t;
    typedef logic [31:0] ticks_t;

    localparam op_t OP_TICK   = 2'd0;
    localparam op_t OP_DELAY  = 2'd1;
    localparam op_t OP_CREATE = 2'd2;
    localparam op_t OP_START  = 2'd3;

    // Per-slot verdict of the shared evaluation unit
    typedef struct packed {
        logic dec;   // write back a decremented delay count
        logic wake;  // count reached zero, clear blocked mark
        logic take;  // slot beats the best candidate so far
    } slot_eval_t;

endpackage

FILE: rtl/pts_if.sv
`timescale 1ns / 1ps
interface pts_cmd_if;
    logic                valid;
    logic                ready;
    pts_pkg::op_t        operation;
    pts_pkg::slot_t      slot;
    pts_pkg::prio_t      priority_req;
    pts_pkg::ticks_t     delay_ticks;

    modport source (output valid, output operation, output slot,
                    output priority_req, output delay_ticks, input ready);
    modport sink   (input valid, input operation, input slot,
                    input priority_req, input delay_ticks, output ready);
endinterface

interface pts_rsp_if;
    logic                valid;
    logic                ready;
    pts_pkg::slot_t      selected_task;
    logic                selected_is_idle;
    logic                switch_needed;
    pts_pkg::ticks_t     tick_value;

    modport source (output valid, output selected_task, output selected_is_idle,
                    output switch_needed, output tick_value, input ready);
    modport sink   (input valid, input selected_task, input selected_is_idle,
                    input switch_needed, input tick_value, output ready);
endinterface

FILE: rtl/pts_ram.sv
`timescale 1ns / 1ps
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/pts_slot_alu.sv
`timescale 1ns / 1ps
module pts_slot_alu #(
    parameter int DELAY_BITS = 32
) (
    input  logic                   tick_op,
    input  logic                   in_use,
    input  logic                   blocked,
    input  pts_pkg::prio_t         prio,
    input  logic [DELAY_BITS-1:0]  delay,
    input  logic                   best_idle,
    input  pts_pkg::prio_t         best_prio,
    output logic [DELAY_BITS-1:0]  delay_dec,
    output pts_pkg::slot_eval_t    eval
);

    logic slot_ready;

    always_comb
    begin
        delay_dec  = delay - DELAY_BITS'(1);
        eval.dec   = tick_op && in_use && blocked && (delay != '0);
        eval.wake  = eval.dec && (delay_dec == '0);
        slot_ready = in_use && (!blocked || eval.wake);
        // strict compare keeps ties on the lower slot
        eval.take  = slot_ready && (best_idle || (prio > best_prio));
    end

endmodule

FILE: rtl/priority_task_scheduler_unit.sv
`timescale 1ns / 1ps
// A result is registered once the walk over all slots is done, and the block takes no
// new command until then. A single evaluation unit walks one slot per cycle through
// the priority and delay RAMs.
// The result register holds a finished response while the next command is taken.
// Reset clears slot flags, tick counter and running task (idle); no RAM clearing pass.
module priority_task_scheduler_unit #(
    parameter int MAX_TASKS  = 16,
    parameter int DELAY_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    pts_cmd_if.sink          cmd,
    pts_rsp_if.source        rsp
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int RW = $clog2(MAX_TASKS + 1);
    localparam logic [RW-1:0] IDLE_CODE = RW'(MAX_TASKS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [MAX_TASKS-1:0]  in_use_reg;
    logic [MAX_TASKS-1:0]  blocked_reg;
    logic [RW-1:0]         running_reg;
    logic [31:0]           tick_reg;
    logic                  tick_op_reg;
    logic [RW-1:0]         rd_cnt_reg;
    logic                  p_vld_reg;
    logic [IW-1:0]         p_idx_reg;
    logic [RW-1:0]         best_reg;
    pts_pkg::prio_t        best_prio_reg;
    logic                  rsp_valid_reg;
    pts_pkg::slot_t        sel_task_reg;
    logic                  sel_idle_reg;
    logic                  switch_reg;
    logic [31:0]           tick_out_reg;

    logic                  accept;
    logic                  is_create;
    logic                  is_delay;
    logic                  is_tick;
    logic [IW-1:0]         create_idx;
    logic [IW-1:0]         run_idx;
    logic                  issue;
    logic                  walk_last;
    logic                  out_free;
    pts_pkg::prio_t        prio_q;
    logic [DELAY_BITS-1:0] delay_q;
    logic [DELAY_BITS-1:0] delay_dec;
    pts_pkg::slot_eval_t   eval;
    logic                  dly_wr_en;
    logic [IW-1:0]         dly_wr_addr;
    logic [DELAY_BITS-1:0] dly_wr_data;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign create_idx = IW'(cmd.slot);
    assign run_idx    = running_reg[IW-1:0];
    assign is_create  = accept && (cmd.operation == pts_pkg::OP_CREATE)
                        && (32'(cmd.slot) < MAX_TASKS);
    assign is_delay   = accept && (cmd.operation == pts_pkg::OP_DELAY)
                        && (running_reg != IDLE_CODE);
    assign is_tick    = accept && (cmd.operation == pts_pkg::OP_TICK);
    assign issue      = (state_reg == ST_WALK) && (rd_cnt_reg < IDLE_CODE);
    assign walk_last  = p_vld_reg && (p_idx_reg == IW'(MAX_TASKS - 1));
    assign out_free   = !rsp_valid_reg || rsp.ready;

    // Delay RAM write: command updates on accept, tick write-back during the walk
    always_comb
    begin
        dly_wr_en   = is_create || is_delay || (p_vld_reg && eval.dec);
        dly_wr_addr = run_idx;
        dly_wr_data = cmd.delay_ticks[DELAY_BITS-1:0];
        if (p_vld_reg)
        begin
            dly_wr_addr = p_idx_reg;
            dly_wr_data = delay_dec;
        end
        else if (is_create)
        begin
            dly_wr_addr = create_idx;
            dly_wr_data = '0;
        end
    end

    pts_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TASKS)
    ) u_prio_ram (
        .clk     (clk),
        .wr_en   (is_create),
        .wr_addr (create_idx),
        .wr_data (cmd.priority_req),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[IW-1:0]),
        .rd_data (prio_q)
    );

    pts_ram #(
        .WIDTH (DELAY_BITS),
        .DEPTH (MAX_TASKS)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (dly_wr_en),
        .wr_addr (dly_wr_addr),
        .wr_data (dly_wr_data),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[IW-1:0]),
        .rd_data (delay_q)
    );

    pts_slot_alu #(
        .DELAY_BITS (DELAY_BITS)
    ) u_slot_alu (
        .tick_op   (tick_op_reg),
        .in_use    (in_use_reg[p_idx_reg]),
        .blocked   (blocked_reg[p_idx_reg]),
        .prio      (prio_q),
        .delay     (delay_q),
        .best_idle (best_reg == IDLE_CODE),
        .best_prio (best_prio_reg),
        .delay_dec (delay_dec),
        .eval      (eval)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_use_reg    <= '0;
            blocked_reg   <= '0;
            running_reg   <= IDLE_CODE;
            tick_reg      <= '0;
            rd_cnt_reg    <= '0;
            p_vld_reg     <= 1'b0;
            best_reg      <= IDLE_CODE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (is_create)
            begin
                in_use_reg[create_idx]  <= 1'b1;
                blocked_reg[create_idx] <= 1'b0;
            end
            if (is_delay)
            begin
                blocked_reg[run_idx] <= 1'b1;
            end
            if (p_vld_reg && eval.wake)
            begin
                blocked_reg[p_idx_reg] <= 1'b0;
            end
            if (is_tick)
            begin
                tick_reg <= tick_reg + 32'd1;
            end
            if (accept)
            begin
                rd_cnt_reg <= '0;
                best_reg   <= IDLE_CODE;
            end
            else if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + RW'(1);
            end
            p_vld_reg <= issue;
            if (p_vld_reg && eval.take)
            begin
                best_reg <= RW'(p_idx_reg);
            end
            if (state_reg == ST_FIN && out_free)
            begin
                rsp_valid_reg <= 1'b1;
                running_reg   <= best_reg;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_op_reg <= (cmd.operation == pts_pkg::OP_TICK);
        end
        if (issue)
        begin
            p_idx_reg <= rd_cnt_reg[IW-1:0];
        end
        if (p_vld_reg && eval.take)
        begin
            best_prio_reg <= prio_q;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            sel_task_reg <= (best_reg == IDLE_CODE) ? 4'd0 : 4'(best_reg);
            sel_idle_reg <= (best_reg == IDLE_CODE);
            switch_reg   <= (best_reg != running_reg);
            tick_out_reg <= tick_reg;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.selected_task    = sel_task_reg;
    assign rsp.selected_is_idle = sel_idle_reg;
    assign rsp.switch_needed    = switch_reg;
    assign rsp.tick_value       = tick_out_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd.ready)
        else $error("command taken while a walk is starting");

    a_running_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg <= IDLE_CODE)
        else $error("running task code out of range");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("response raised outside the finish step");

    a_idle_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.selected_is_idle |-> rsp.selected_task == 4'd0)
        else $error("idle selection with nonzero slot");

    a_walk_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> (state_reg == ST_WALK) && (RW'(p_idx_reg) < IDLE_CODE))
        else $error("slot evaluation outside the walk");
`endif

endmodule

FILE: tb/sv/tb_priority_task_scheduler_unit.sv
`timescale 1ns / 1ps
module tb_priority_task_scheduler_unit;

    localparam int N_SLOTS        = 16;
    localparam int DELAY_W        = 32;
    localparam int IDLE_SLOT      = N_SLOTS;
    localparam int DUT_LATENCY    = N_SLOTS + 2;
    localparam int RANDOM_ITEMS   = 1925;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        pts_pkg::slot_t  task_idx;
        logic            idle;
        logic            switched;
        pts_pkg::ticks_t tick;
    } sched_result_t;

    // Tracks the task table and queues the selection each command should produce
    class sched_scoreboard;
        bit              in_use[N_SLOTS];
        bit              blocked[N_SLOTS];
        pts_pkg::prio_t  prio[N_SLOTS];
        pts_pkg::ticks_t delay_left[N_SLOTS];
        int unsigned     running;
        pts_pkg::ticks_t tick_ctr;
        sched_result_t   selection_q[$];
        int              errors;
        int              op_count[4];
        int              results;
        int              switches;
        int              idle_picks;
        int              wakeups;

        function new();
            foreach (in_use[i])
            begin
                in_use[i]     = 1'b0;
                blocked[i]    = 1'b0;
                prio[i]       = '0;
                delay_left[i] = '0;
            end
            running    = IDLE_SLOT;
            tick_ctr   = '0;
            errors     = 0;
            results    = 0;
            switches   = 0;
            idle_picks = 0;
            wakeups    = 0;
            foreach (op_count[i])
                op_count[i] = 0;
        endfunction

        function void note_command(pts_pkg::op_t op, pts_pkg::slot_t slot,
                                   pts_pkg::prio_t p, pts_pkg::ticks_t ticks);
            sched_result_t sel;
            int unsigned   best;
            op_count[op]++;
            case (op)
                pts_pkg::OP_TICK:
                begin
                    tick_ctr++;
                    for (int i = 0; i < N_SLOTS; i++)
                    begin
                        if (in_use[i] && blocked[i] && delay_left[i] != '0)
                        begin
                            delay_left[i]--;
                            if (delay_left[i] == '0)
                            begin
                                blocked[i] = 1'b0;
                                wakeups++;
                            end
                        end
                    end
                end
                pts_pkg::OP_DELAY:
                begin
                    if (running != IDLE_SLOT)
                    begin
                        delay_left[running] = ticks;
                        blocked[running]    = 1'b1;
                    end
                end
                pts_pkg::OP_CREATE:
                begin
                    in_use[slot]     = 1'b1;
                    blocked[slot]    = 1'b0;
                    prio[slot]       = p;
                    delay_left[slot] = '0;
                end
                pts_pkg::OP_START: ;
                default: ;
            endcase

            // highest priority wins, ties go to the lowest index
            best = IDLE_SLOT;
            for (int i = 0; i < N_SLOTS; i++)
            begin
                if (in_use[i] && !blocked[i] && (best == IDLE_SLOT || prio[i] > prio[best]))
                    best = i;
            end
            sel.task_idx = (best == IDLE_SLOT) ? pts_pkg::slot_t'(0) : pts_pkg::slot_t'(best);
            sel.idle     = (best == IDLE_SLOT);
            sel.switched = (best != running);
            sel.tick     = tick_ctr;
            if (sel.switched)
                switches++;
            if (sel.idle)
                idle_picks++;
            running = best;
            selection_q.push_back(sel);
        endfunction

        function void report(string field, longint unsigned exp_v, longint unsigned act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            results++;
            if (selection_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual task %0d idle %0b",
                         $time, got.task_idx, got.idle);
                return;
            end
            want = selection_q.pop_front();
            if (got.task_idx !== want.task_idx)
                report("selected_task", want.task_idx, got.task_idx);
            if (got.idle !== want.idle)
                report("selected_is_idle", want.idle, got.idle);
            if (got.switched !== want.switched)
                report("switch_needed", want.switched, got.switched);
            if (got.tick !== want.tick)
                report("tick_value", want.tick, got.tick);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pts_cmd_if cmd_if ();
    pts_rsp_if rsp_if ();

    priority_task_scheduler_unit #(
        .MAX_TASKS  (N_SLOTS),
        .DELAY_BITS (DELAY_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    sched_scoreboard sb = new();
    bit              quiet_stretch = 1'b0;
    int              sent = 0;
    int              idle_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one command, with random idle cycles ahead of it unless quiet_stretch is set, and hold until accepted
    task automatic send_cmd(input pts_pkg::op_t op, input pts_pkg::slot_t slot,
                            input pts_pkg::prio_t p, input pts_pkg::ticks_t ticks);
        if (!quiet_stretch)
        begin
            while ($urandom_range(0, 99) < 25)
            begin
                cmd_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.operation    <= op;
        cmd_if.slot         <= slot;
        cmd_if.priority_req <= p;
        cmd_if.delay_ticks  <= ticks;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        sb.note_command(op, slot, p, ticks);
        sent++;
    endtask

    // Result side: random stalls plus one long hold-off to back the block up
    initial
    begin : result_side
        int  hold_left;
        bit  hold_done;
        sched_result_t got;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                got.task_idx = rsp_if.selected_task;
                got.idle     = rsp_if.selected_is_idle;
                got.switched = rsp_if.switch_needed;
                got.tick     = rsp_if.tick_value;
                sb.check_result(got);
            end
            if (!rst_n)
                rsp_if.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (!hold_done && sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= quiet_stretch || ($urandom_range(0, 99) >= 25);
        end
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, sb.selection_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        pts_pkg::op_t    op;
        pts_pkg::slot_t  slot;
        pts_pkg::prio_t  p;
        pts_pkg::ticks_t ticks;
        int              r;
        rst_n               <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.operation    <= pts_pkg::OP_START;
        cmd_if.slot         <= '0;
        cmd_if.priority_req <= '0;
        cmd_if.delay_ticks  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, then ties, wakeups, endless blocks and slot replacement
        send_cmd(pts_pkg::OP_START,  4'd0,  8'd0,   32'd0);
        send_cmd(pts_pkg::OP_TICK,   4'd15, 8'hFF,  32'hFFFF_FFFF);
        send_cmd(pts_pkg::OP_DELAY,  4'd3,  8'd0,   32'd5);
        send_cmd(pts_pkg::OP_CREATE, 4'd0,  8'd0,   32'd7);
        send_cmd(pts_pkg::OP_START,  4'd9,  8'd1,   32'd0);
        send_cmd(pts_pkg::OP_CREATE, 4'd15, 8'hFF,  32'd0);
        send_cmd(pts_pkg::OP_CREATE, 4'd5,  8'hFF,  32'd0);
        send_cmd(pts_pkg::OP_DELAY,  4'd0,  8'd0,   32'd1);
        send_cmd(pts_pkg::OP_TICK,   4'd0,  8'd0,   32'd0);
        send_cmd(pts_pkg::OP_DELAY,  4'd0,  8'd0,   32'd0);
        send_cmd(pts_pkg::OP_TICK,   4'd0,  8'd0,   32'd0);
        send_cmd(pts_pkg::OP_TICK,   4'd0,  8'd0,   32'd0);
        send_cmd(pts_pkg::OP_DELAY,  4'd0,  8'd0,   32'hFFFF_FFFF);
        send_cmd(pts_pkg::OP_DELAY,  4'd0,  8'd0,   32'd2);
        send_cmd(pts_pkg::OP_DELAY,  4'd0,  8'd0,   32'd3);
        send_cmd(pts_pkg::OP_TICK,   4'd0,  8'd0,   32'd0);
        send_cmd(pts_pkg::OP_TICK,   4'd0,  8'd0,   32'd0);
        send_cmd(pts_pkg::OP_CREATE, 4'd5,  8'hAA,  32'h5555_5555);
        send_cmd(pts_pkg::OP_CREATE, 4'd10, 8'h55,  32'hAAAA_AAAA);
        send_cmd(pts_pkg::OP_CREATE, 4'd5,  8'h01,  32'd0);
        send_cmd(pts_pkg::OP_DELAY,  4'd0,  8'd0,   32'h8000_0001);
        send_cmd(pts_pkg::OP_CREATE, 4'd15, 8'h0F,  32'd0);
        send_cmd(pts_pkg::OP_START,  4'd6,  8'h80,  32'd0);
        send_cmd(pts_pkg::OP_TICK,   4'd0,  8'd0,   32'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_stretch = (n >= 700 && n < 1000);
            r = $urandom_range(0, 99);
            if (r < 40)
                op = pts_pkg::OP_TICK;
            else if (r < 62)
                op = pts_pkg::OP_DELAY;
            else if (r < 88)
                op = pts_pkg::OP_CREATE;
            else
                op = pts_pkg::OP_START;
            slot = pts_pkg::slot_t'($urandom_range(0, N_SLOTS - 1));
            // mostly a few levels so ties are common
            p = ($urandom_range(0, 3) == 0) ? pts_pkg::prio_t'($urandom_range(0, 255))
                                            : pts_pkg::prio_t'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 6)
                ticks = '0;
            else if (r < 12)
                ticks = $urandom();
            else
                ticks = pts_pkg::ticks_t'($urandom_range(1, 8));
            send_cmd(op, slot, p, ticks);
        end
        quiet_stretch = 1'b0;
        cmd_if.valid <= 1'b0;

        while (sb.selection_q.size() != 0)
            @(posedge clk);
        repeat (2 * DUT_LATENCY) @(posedge clk);

        $display("Sent %0d commands: %0d ticks, %0d delays, %0d creates, %0d starts.",
                 sent, sb.op_count[pts_pkg::OP_TICK], sb.op_count[pts_pkg::OP_DELAY],
                 sb.op_count[pts_pkg::OP_CREATE], sb.op_count[pts_pkg::OP_START]);
        $display("Checked %0d results: %0d switches, %0d idle selections, %0d wakeups.",
                 sb.results, sb.switches, sb.idle_picks, sb.wakeups);
        if (sb.errors == 0 && sb.selection_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pts_pkg.sv
rtl/pts_if.sv
rtl/pts_ram.sv
rtl/pts_slot_alu.sv
rtl/priority_task_scheduler_unit.sv
tb/sv/tb_priority_task_scheduler_unit.sv
